FILE: hdl/bpa_pkg.sv
// Shared constants, payload types and table functions for the bouncing point advance block.
package bpa_pkg;

  // Geometry and number formats
  localparam int MAX_DIM     = 1024;
  localparam int FRAC_BITS   = 8;
  localparam int PHASE_BITS  = 16;
  localparam int POS_W       = 18;
  localparam int HEAD_W      = 16;
  localparam int DIM_W       = 11;
  localparam int SPEED_W     = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 15;
  localparam int LIM_W       = DIM_W + FRAC_BITS;

  // Sine table and interpolation
  localparam int UNIT_SHIFT   = 14;
  localparam int SINE_W       = UNIT_SHIFT + 1;
  localparam int SINE_STEPS   = 32;
  localparam int INTERP_BITS  = PHASE_BITS - 7;
  localparam int IDX_W        = PHASE_BITS - 1 - INTERP_BITS;
  localparam int DIFF_W       = 10;
  localparam int QUARTER_TURN = 1 << (PHASE_BITS - 2);
  localparam int HALF_TURN    = 1 << (PHASE_BITS - 1);

  // Displacement magnitude and signed coordinate width before reflection
  localparam int DISP_W = 16;
  localparam int WIDE_W = POS_W + 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA_WIDTH  = 2'd0,
    CFG_AREA_HEIGHT = 2'd1,
    CFG_STEP_SPEED  = 2'd2
  } cfg_idx_e;

  // Request payloads
  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [HEAD_W-1:0] heading;
  } bpa_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  new_x;
    logic [POS_W-1:0]  new_y;
    logic [HEAD_W-1:0] new_heading;
    logic              hit_side;
    logic              hit_top_bottom;
  } bpa_out_t;

  // Which walls of one axis reflected a coordinate
  typedef struct packed {
    logic low;
    logic high;
  } bpa_hit_t;

  // Quarter-wave sine table in Q1.14, one entry per 1/128 turn
  function automatic logic [SINE_W-1:0] sine_entry(input logic [IDX_W-1:0] idx);
    logic [SINE_W-1:0] val;
    case (int'(idx))
      0:  val = SINE_W'(0);
      1:  val = SINE_W'(804);
      2:  val = SINE_W'(1606);
      3:  val = SINE_W'(2404);
      4:  val = SINE_W'(3196);
      5:  val = SINE_W'(3981);
      6:  val = SINE_W'(4756);
      7:  val = SINE_W'(5520);
      8:  val = SINE_W'(6270);
      9:  val = SINE_W'(7005);
      10: val = SINE_W'(7723);
      11: val = SINE_W'(8423);
      12: val = SINE_W'(9102);
      13: val = SINE_W'(9760);
      14: val = SINE_W'(10394);
      15: val = SINE_W'(11003);
      16: val = SINE_W'(11585);
      17: val = SINE_W'(12140);
      18: val = SINE_W'(12665);
      19: val = SINE_W'(13160);
      20: val = SINE_W'(13623);
      21: val = SINE_W'(14053);
      22: val = SINE_W'(14449);
      23: val = SINE_W'(14811);
      24: val = SINE_W'(15137);
      25: val = SINE_W'(15426);
      26: val = SINE_W'(15679);
      27: val = SINE_W'(15893);
      28: val = SINE_W'(16069);
      29: val = SINE_W'(16207);
      30: val = SINE_W'(16305);
      31: val = SINE_W'(16364);
      32: val = SINE_W'(16384);
      default: val = SINE_W'(0);
    endcase
    return val;
  endfunction

  // Area size as used: zero counts as one pixel, large values saturate
  function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

FILE: hdl/bpa_in_if.sv
// Point request channel: valid/ready handshake with the point payload.
interface bpa_in_if;
  import bpa_pkg::*;

  logic    valid;
  logic    ready;
  bpa_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/bpa_out_if.sv
// Result request channel: valid/ready handshake with the advanced point payload.
interface bpa_out_if;
  import bpa_pkg::*;

  logic     valid;
  logic     ready;
  bpa_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/bpa_sine.sv
// Sine lookup with linear interpolation: magnitude in Q1.14 and a sign bit.
module bpa_sine (
  input  logic [bpa_pkg::PHASE_BITS-1:0] phase_i,
  output logic [bpa_pkg::SINE_W-1:0]     mag_o,
  output logic                           neg_o
);
  import bpa_pkg::*;

  logic [1:0]                      quad;
  logic [PHASE_BITS-3:0]           quad_off;
  logic [PHASE_BITS-2:0]           folded;
  logic [IDX_W-1:0]                idx;
  logic [INTERP_BITS-1:0]          frac;
  logic [SINE_W-1:0]               lo_val;
  logic [SINE_W-1:0]               hi_val;
  logic [SINE_W-1:0]               diff_full;
  logic [DIFF_W-1:0]               diff;
  logic [DIFF_W+INTERP_BITS-1:0]   prod;
  logic [DIFF_W+INTERP_BITS:0]     rounded;
  logic [DIFF_W-1:0]               interp;
  logic [SINE_W-1:0]               sum;

  // Fold the phase into the first quadrant
  assign quad     = phase_i[PHASE_BITS-1 -: 2];
  assign quad_off = phase_i[PHASE_BITS-3:0];
  assign folded   = quad[0] ? ((PHASE_BITS-1)'(QUARTER_TURN) - {1'b0, quad_off})
                            : {1'b0, quad_off};
  assign idx      = folded[PHASE_BITS-2:INTERP_BITS];
  assign frac     = folded[INTERP_BITS-1:0];

  // Neighbouring table entries; the upper one is unused at the quarter point
  assign lo_val    = sine_entry(idx);
  assign hi_val    = sine_entry(IDX_W'(idx + 1'b1));
  assign diff_full = hi_val - lo_val;
  assign diff      = diff_full[DIFF_W-1:0];

  // Interpolate with round-half-up on the fraction
  assign prod    = (DIFF_W+INTERP_BITS)'(diff) * (DIFF_W+INTERP_BITS)'(frac);
  assign rounded = {1'b0, prod} + (DIFF_W+INTERP_BITS+1)'(1 << (INTERP_BITS - 1));
  assign interp  = rounded[DIFF_W+INTERP_BITS-1:INTERP_BITS];
  assign sum     = lo_val + SINE_W'(interp);

  assign mag_o = (idx >= IDX_W'(SINE_STEPS)) ? SINE_W'(1 << UNIT_SHIFT) : sum;
  assign neg_o = quad[1];

endmodule

FILE: hdl/bpa_reflect.sv
// Mirrors one moved coordinate off the low and high walls and clamps what is left over.
module bpa_reflect (
  input  logic signed [bpa_pkg::WIDE_W-1:0] coord_i,
  input  logic [bpa_pkg::DIM_W-1:0]         dim_i,
  output logic [bpa_pkg::POS_W-1:0]         pos_o,
  output bpa_pkg::bpa_hit_t                 hit_o
);
  import bpa_pkg::*;

  logic signed [WIDE_W-1:0] lim;
  logic signed [WIDE_W-1:0] lim2;
  logic signed [WIDE_W-1:0] after_low;
  logic signed [WIDE_W-1:0] after_high;
  logic signed [WIDE_W-1:0] clamped;

  // Wall position in fixed point
  assign lim  = signed'(WIDE_W'({dim_i, FRAC_BITS'(0)}));
  assign lim2 = lim <<< 1;

  // Low wall first, then the high wall on the mirrored value
  assign hit_o.low  = coord_i < 0;
  assign after_low  = hit_o.low ? -coord_i : coord_i;
  assign hit_o.high = after_low >= lim;
  assign after_high = hit_o.high ? (lim2 - after_low) : after_low;

  // Clamp anything that a single reflection did not bring back inside
  always_comb begin
    if (after_high < 0) begin
      clamped = '0;
    end else if (after_high >= lim) begin
      clamped = lim - WIDE_W'(1);
    end else begin
      clamped = after_high;
    end
  end

  assign pos_o = clamped[POS_W-1:0];

endmodule

FILE: hdl/bouncing_point_advance.sv
// Top level of the bouncing point advance block: four-stage point pipeline and register port.
//
// Each request carries one point and leaves as one result; a new point is taken in every cycle
// unless every stage is full and the output is blocked. The pipeline holds an input register, a
// sine stage (table read and interpolation for both axes), a displacement stage (speed times
// sine with rounding) and a result register after the add, wall reflection and heading flips.
// Each stage moves on when the one after it is empty or moving, so a result waiting at the
// output does not stop new points until every stage is full. Area width, area height and speed
// are to be written by the user via the register port only while no point is in flight; the block
// does not enforce this. Area sizes of zero count as one pixel and sizes above 1024 saturate.
module bouncing_point_advance (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bpa_in_if.sink                        in_i,
  bpa_out_if.source                     out_o
);
  import bpa_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;
  logic [SPEED_W-1:0] speed_q;
  logic [DIM_W-1:0]   width_lim;
  logic [DIM_W-1:0]   height_lim;

  // Stage valids and ready chain
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1: input register
  bpa_in_t s1_q;

  // Stage 2: sines
  logic [POS_W-1:0]  s2_px_q, s2_py_q;
  logic [HEAD_W-1:0] s2_head_q;
  logic [SINE_W-1:0] s2_cos_mag_q, s2_sin_mag_q;
  logic              s2_cos_neg_q, s2_sin_neg_q;

  // Stage 3: displacements
  logic [POS_W-1:0]  s3_px_q, s3_py_q;
  logic [HEAD_W-1:0] s3_head_q;
  logic [DISP_W-1:0] s3_dx_q, s3_dy_q;
  logic              s3_dx_neg_q, s3_dy_neg_q;

  // Stage 4: result register
  bpa_out_t s4_q;

  // Combinational signals between stages
  logic [PHASE_BITS-1:0]          cos_phase;
  logic [SINE_W-1:0]              cos_mag, sin_mag;
  logic                           cos_neg, sin_neg;
  logic [SPEED_W+SINE_W-1:0]      prod_x, prod_y;
  logic [SPEED_W+SINE_W:0]        rnd_x, rnd_y;
  logic signed [WIDE_W-1:0]       px_w, py_w, dx_w, dy_w, x_moved, y_moved;
  logic [POS_W-1:0]               x_new, y_new;
  bpa_hit_t                       hit_x, hit_y;
  logic [HEAD_W-1:0]              head_after_x, head_after_y;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(32);
      height_q <= DIM_W'(32);
      speed_q  <= SPEED_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_AREA_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_AREA_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        CFG_STEP_SPEED:  speed_q  <= cfg_data_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign width_lim  = limit_dim(width_q);
  assign height_lim = limit_dim(height_q);

  // A stage can load when it is empty or its content moves on
  assign rdy4 = !v4_q || out_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  // Stage 1: capture the request
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) begin
      s1_q <= in_i.data;
    end
  end

  // Stage 2: cosine is the sine a quarter turn ahead
  assign cos_phase = s1_q.heading + PHASE_BITS'(QUARTER_TURN);

  bpa_sine u_cos (
    .phase_i (cos_phase),
    .mag_o   (cos_mag),
    .neg_o   (cos_neg)
  );

  bpa_sine u_sin (
    .phase_i (s1_q.heading),
    .mag_o   (sin_mag),
    .neg_o   (sin_neg)
  );

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_px_q      <= s1_q.pos_x;
      s2_py_q      <= s1_q.pos_y;
      s2_head_q    <= s1_q.heading;
      s2_cos_mag_q <= cos_mag;
      s2_cos_neg_q <= cos_neg;
      s2_sin_mag_q <= sin_mag;
      s2_sin_neg_q <= sin_neg;
    end
  end

  // Stage 3: speed times sine, rounded to the nearest Q.8 step
  assign prod_x = (SPEED_W+SINE_W)'(speed_q) * (SPEED_W+SINE_W)'(s2_cos_mag_q);
  assign prod_y = (SPEED_W+SINE_W)'(speed_q) * (SPEED_W+SINE_W)'(s2_sin_mag_q);
  assign rnd_x  = {1'b0, prod_x} + (SPEED_W+SINE_W+1)'(1 << (UNIT_SHIFT - 1));
  assign rnd_y  = {1'b0, prod_y} + (SPEED_W+SINE_W+1)'(1 << (UNIT_SHIFT - 1));

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_px_q     <= s2_px_q;
      s3_py_q     <= s2_py_q;
      s3_head_q   <= s2_head_q;
      s3_dx_q     <= rnd_x[UNIT_SHIFT+DISP_W-1:UNIT_SHIFT];
      s3_dy_q     <= rnd_y[UNIT_SHIFT+DISP_W-1:UNIT_SHIFT];
      s3_dx_neg_q <= s2_cos_neg_q;
      s3_dy_neg_q <= s2_sin_neg_q;
    end
  end

  // Stage 4: move, reflect and flip the heading
  assign px_w    = signed'(WIDE_W'(s3_px_q));
  assign py_w    = signed'(WIDE_W'(s3_py_q));
  assign dx_w    = signed'(WIDE_W'(s3_dx_q));
  assign dy_w    = signed'(WIDE_W'(s3_dy_q));
  assign x_moved = s3_dx_neg_q ? (px_w - dx_w) : (px_w + dx_w);
  assign y_moved = s3_dy_neg_q ? (py_w - dy_w) : (py_w + dy_w);

  bpa_reflect u_reflect_x (
    .coord_i (x_moved),
    .dim_i   (width_lim),
    .pos_o   (x_new),
    .hit_o   (hit_x)
  );

  bpa_reflect u_reflect_y (
    .coord_i (y_moved),
    .dim_i   (height_lim),
    .pos_o   (y_new),
    .hit_o   (hit_y)
  );

  // Two flips on one axis cancel, so only an odd count changes the heading
  assign head_after_x = (hit_x.low ^ hit_x.high) ? (HEAD_W'(HALF_TURN) - s3_head_q)
                                                 : s3_head_q;
  assign head_after_y = (hit_y.low ^ hit_y.high) ? (HEAD_W'(0) - head_after_x)
                                                 : head_after_x;

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      s4_q.new_x          <= x_new;
      s4_q.new_y          <= y_new;
      s4_q.new_heading    <= head_after_y;
      s4_q.hit_side       <= hit_x.low | hit_x.high;
      s4_q.hit_top_bottom <= hit_y.low | hit_y.high;
    end
  end

  assign out_o.valid = v4_q;
  assign out_o.data  = s4_q;

  // An accepted request always lands in the input register
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted request did not reach the input register");

  // A point in the displacement stage waits while the result register is blocked
  a_stage_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !rdy4) |=> v3_q)
    else $error("point lost from the displacement stage during a stall");

  // A point that moves out of the displacement stage fills the result register
  a_result_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4) |=> v4_q)
    else $error("point did not reach the result register");

endmodule
